[rtl/core/sensor_window_int8_quantizer_defines.svh]
// Assertion macros of the sensor window quantizer RTL.
// Depends on nothing; included by swq_ctrl, the module that carries assertions.
`ifndef SENSOR_WINDOW_INT8_QUANTIZER_DEFINES_SVH
`define SENSOR_WINDOW_INT8_QUANTIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swq_pkg.sv]
// Types and constants of the sensor window int8 quantizer.
// No dependencies; imported by the controller, datapath, top level and testbench.
package swq_pkg;

  localparam int DATA_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int Q_W       = 8;
  localparam int SLOT_W    = 5;
  localparam int NUM_CH    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = DATA_W + GAIN_W;
  localparam int ITEM_W    = NUM_CH * DATA_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_GAIN = 3'd5;

  // Reset values of the configuration registers.
  localparam logic signed [DATA_W-1:0] TEMP_MIN_RST   = -24'sd2867;
  localparam logic [GAIN_W-1:0]        TEMP_GAIN_RST  = 16'd1343;
  localparam logic signed [DATA_W-1:0] HUM_MIN_RST    = 24'sd3840;
  localparam logic [GAIN_W-1:0]        HUM_GAIN_RST   = 16'd777;
  localparam logic signed [DATA_W-1:0] PRESS_MIN_RST  = 24'sd249907;
  localparam logic [GAIN_W-1:0]        PRESS_GAIN_RST = 16'd983;

  typedef struct packed {
    logic signed [DATA_W-1:0] temperature;
    logic signed [DATA_W-1:0] humidity;
    logic signed [DATA_W-1:0] pressure;
  } swq_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q_temp;
    logic signed [Q_W-1:0] q_hum;
    logic signed [Q_W-1:0] q_press;
    logic [SLOT_W-1:0]     slot;
    logic                  last;
  } swq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;       // store the accepted reading in the window
    logic load_first;  // capture the first reading after reset
    logic rd_en;       // issue one window slot into the pipeline
    logic use_first;   // slot predates all stored readings
    logic last;        // slot is the newest one
  } swq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;         // pipeline moves on this cycle
  } swq_stat_t;

endpackage

[rtl/core/swq_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swq_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 24
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/swq_ctrl.sv]
// Controller of the sensor window quantizer: window pointers, fill tracking
// and the per-slot sequencer. Depends on swq_pkg and the assertion macros.
module swq_ctrl #(
  parameter int WINDOW_LEN = 24
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  swq_pkg::swq_stat_t                                stat,
  output swq_pkg::swq_cmd_t                                 cmd,
  output logic [((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1)-1:0] wr_addr,
  output logic [((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1)-1:0] rd_addr,
  output logic [swq_pkg::SLOT_W-1:0]                        slot
);

  import swq_pkg::*;
  `include "sensor_window_int8_quantizer_defines.svh"

  localparam int AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int GAP_W = $clog2(WINDOW_LEN + 1);
  localparam logic [AW-1:0]    LAST_IDX = AW'(WINDOW_LEN - 1);
  localparam logic [GAP_W-1:0] GAP_RST  = GAP_W'(WINDOW_LEN);
  localparam logic [GAP_W-1:0] GAP_INIT = GAP_W'(WINDOW_LEN - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic             primed_r, primed_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [GAP_W-1:0] gap_r, gap_nxt;
  logic [AW-1:0]    wp_inc;
  logic             acc;

  assign acc    = in_valid && (state_r == ST_IDLE);
  assign wp_inc = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cnt_nxt    = cnt_r;
    gap_nxt    = gap_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          // The new reading lands at the write pointer; the oldest slot then
          // sits just after it.
          state_nxt  = ST_RUN;
          primed_nxt = 1'b1;
          wp_nxt     = wp_inc;
          rp_nxt     = wp_inc;
          cnt_nxt    = '0;
          if (!primed_r) begin
            gap_nxt = GAP_INIT;
          end else if (gap_r != '0) begin
            gap_nxt = gap_r - 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (stat.adv) begin
          cnt_nxt = cnt_r + 1'b1;
          rp_nxt  = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      primed_r <= 1'b0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
      gap_r    <= GAP_RST;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      cnt_r    <= cnt_nxt;
      gap_r    <= gap_nxt;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cmd.wr_en      = acc;
  assign cmd.load_first = acc && !primed_r;
  assign cmd.rd_en      = (state_r == ST_RUN);
  // Slots older than every stored reading repeat the first reading.
  assign cmd.use_first  = GAP_W'(cnt_r) < gap_r;
  assign cmd.last       = (cnt_r == LAST_IDX);
  assign wr_addr        = wp_r;
  assign rd_addr        = rp_r;
  assign slot           = SLOT_W'(cnt_r);

  `SWQ_ASSERT_NEXT(a_accept_starts_run, clk, rst_n, in_valid && !in_stall,
                   cmd.rd_en && cnt_r == '0, "run did not start at slot zero")
  `SWQ_ASSERT_NEXT(a_last_ends_run, clk, rst_n, cmd.rd_en && cmd.last && stat.adv,
                   !cmd.rd_en, "sequencer ran past the newest slot")
  `SWQ_ASSERT_NOW(a_gap_bound, clk, rst_n, primed_r, gap_r < GAP_RST,
                  "fill gap out of range after the first reading")
  `SWQ_ASSERT_NOW(a_rd_addr_bound, clk, rst_n, cmd.rd_en, rp_r <= LAST_IDX,
                  "read pointer beyond the window")

endmodule

[rtl/core/swq_datapath.sv]
// Datapath of the sensor window quantizer: configuration registers, window
// RAM, subtract/multiply/clamp pipeline and output register.
// Depends on swq_pkg and swq_ram.
module swq_datapath #(
  parameter int WINDOW_LEN = 24
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  swq_pkg::swq_cmd_t                                 cmd,
  output swq_pkg::swq_stat_t                                stat,
  input  logic [((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1)-1:0] wr_addr,
  input  logic [((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1)-1:0] rd_addr,
  input  logic [swq_pkg::SLOT_W-1:0]                        slot,
  input  swq_pkg::swq_in_t                                  in_data,
  output logic                                              out_valid,
  input  logic                                              out_stall,
  output swq_pkg::swq_out_t                                 out_data,
  input  logic                                              cfg_we,
  input  logic [swq_pkg::CFG_IDX_W-1:0]                     cfg_index,
  input  logic [swq_pkg::DATA_W-1:0]                        cfg_wdata
);

  import swq_pkg::*;

  // Configuration registers.
  logic signed [DATA_W-1:0] temp_min_r, hum_min_r, press_min_r;
  logic [GAIN_W-1:0]        temp_gain_r, hum_gain_r, press_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_min_r   <= TEMP_MIN_RST;
      temp_gain_r  <= TEMP_GAIN_RST;
      hum_min_r    <= HUM_MIN_RST;
      hum_gain_r   <= HUM_GAIN_RST;
      press_min_r  <= PRESS_MIN_RST;
      press_gain_r <= PRESS_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_MIN:   temp_min_r   <= cfg_wdata;
        CFG_TEMP_GAIN:  temp_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_HUM_MIN:    hum_min_r    <= cfg_wdata;
        CFG_HUM_GAIN:   hum_gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_PRESS_MIN:  press_min_r  <= cfg_wdata;
        CFG_PRESS_GAIN: press_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign stat.adv = adv;

  // Window store and first reading.
  logic [ITEM_W-1:0] ram_rdata;
  swq_in_t           first_r;

  swq_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (ITEM_W'(in_data)),
    .re    (cmd.rd_en && adv),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      first_r <= in_data;
    end
  end

  // Pipeline valid bits: A holds the RAM read, B the offsets, C the products.
  logic va_r, vb_r, vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= cmd.rd_en;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      out_valid_r <= vc_r;
    end
  end

  // Stage tags travel with the data.
  logic              a_first_r, a_last_r, b_last_r, c_last_r;
  logic [SLOT_W-1:0] a_slot_r, b_slot_r, c_slot_r;

  swq_in_t                  x_a;
  logic signed [DATA_W-1:0] xs   [NUM_CH];
  logic signed [DATA_W-1:0] mins [NUM_CH];
  logic [GAIN_W-1:0]        gains[NUM_CH];
  logic signed [DATA_W:0]   diff [NUM_CH];
  logic [DATA_W-1:0]        dm_nxt[NUM_CH];
  logic [DATA_W-1:0]        dm_r [NUM_CH];
  logic [PROD_W-1:0]        prod_r[NUM_CH];
  logic [DATA_W-1:0]        u_hi [NUM_CH];
  logic [Q_W-1:0]           u8   [NUM_CH];
  logic [Q_W-1:0]           q    [NUM_CH];
  swq_out_t                 out_r;

  assign x_a      = a_first_r ? first_r : swq_in_t'(ram_rdata);
  assign xs[0]    = x_a.temperature;
  assign xs[1]    = x_a.humidity;
  assign xs[2]    = x_a.pressure;
  assign mins[0]  = temp_min_r;
  assign mins[1]  = hum_min_r;
  assign mins[2]  = press_min_r;
  assign gains[0] = temp_gain_r;
  assign gains[1] = hum_gain_r;
  assign gains[2] = press_gain_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff[c] = {xs[c][DATA_W-1], xs[c]} - {mins[c][DATA_W-1], mins[c]};
      // A reading at or below the lower bound maps to the lowest code, -128.
      dm_nxt[c] = (!diff[c][DATA_W] && (diff[c] != '0)) ? diff[c][DATA_W-1:0] : '0;
      u_hi[c]   = prod_r[c][PROD_W-1:GAIN_W];
      u8[c]     = (|u_hi[c][DATA_W-1:Q_W]) ? {Q_W{1'b1}} : u_hi[c][Q_W-1:0];
      // Subtracting 128 from an unsigned byte is a flip of its top bit.
      q[c]      = {~u8[c][Q_W-1], u8[c][Q_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_first_r <= cmd.use_first;
      a_last_r  <= cmd.last;
      a_slot_r  <= slot;
      b_last_r  <= a_last_r;
      b_slot_r  <= a_slot_r;
      c_last_r  <= b_last_r;
      c_slot_r  <= b_slot_r;
      for (int c = 0; c < NUM_CH; c++) begin
        dm_r[c]   <= dm_nxt[c];
        prod_r[c] <= PROD_W'(dm_r[c]) * PROD_W'(gains[c]);
      end
      out_r.q_temp  <= q[0];
      out_r.q_hum   <= q[1];
      out_r.q_press <= q[2];
      out_r.slot    <= c_slot_r;
      out_r.last    <= c_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/sensor_window_int8_quantizer.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   swq_in_t: temperature, humidity, pressure
// out_      output     out_valid/out_stall swq_out_t: q_temp, q_hum, q_press, slot, last
// cfg_      input      cfg_we              cfg_index selects, cfg_wdata carries the value
//
// Each accepted reading yields WINDOW_LEN results, one per cycle when out_stall is low;
// the slot sequencer issues them and accepts no new reading until the last is issued.
// Each result passes the RAM read, subtract, multiply and clamp stages.
// Reset is synchronous and needs no clearing pass.
// in_stall is high while the slots of the current reading are being issued.
// out_stall freezes the whole slot pipeline and the sequencer while out_valid is high.
// Top level of the sensor window int8 quantizer; depends on swq_pkg,
// swq_ctrl and swq_datapath.
module sensor_window_int8_quantizer #(
  parameter int WINDOW_LEN = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swq_pkg::swq_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swq_pkg::swq_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [swq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swq_pkg::DATA_W-1:0]    cfg_wdata
);

  import swq_pkg::*;

  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  swq_cmd_t          cmd;
  swq_stat_t         stat;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [SLOT_W-1:0] slot;

  swq_ctrl #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .slot     (slot)
  );

  swq_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .slot      (slot),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[test/sensor_window_int8_quantizer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of sensor_window_int8_quantizer: a directed table, then random readings
// under several register settings, every window slot checked against a predictor kept here.
// Depends on swq_pkg and the sensor_window_int8_quantizer RTL.
module sensor_window_int8_quantizer_tb;
  import swq_pkg::*;

  localparam int WINDOW_LEN  = 24;
  localparam int IDLE_SLACK  = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_ROWS    = 24;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] MIN_IDX [NUM_CH] = '{CFG_TEMP_MIN, CFG_HUM_MIN, CFG_PRESS_MIN};
  localparam logic [CFG_IDX_W-1:0] GAIN_IDX [NUM_CH] =
    '{CFG_TEMP_GAIN, CFG_HUM_GAIN, CFG_PRESS_GAIN};

  localparam logic signed [DATA_W-1:0] RD_LO = 24'sh800000;
  localparam logic signed [DATA_W-1:0] RD_HI = 24'sh7FFFFF;
  localparam logic signed [Q_W-1:0]    Q_LO  = 8'sh80;
  localparam logic signed [Q_W-1:0]    Q_HI  = 8'sh7F;

  typedef enum logic {ROW_READING, ROW_WRITE} row_kind_t;

  // Hand-typed codes for the newest slot of a reading, used where chk is set.
  typedef struct packed {
    logic                  chk;
    logic signed [Q_W-1:0] q_temp;
    logic signed [Q_W-1:0] q_hum;
    logic signed [Q_W-1:0] q_press;
  } newest_check_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [DATA_W-1:0]      wdata;
    swq_in_t                reading;
    newest_check_t          want;
  } stim_row_t;

  stim_row_t stim_rows [NUM_ROWS] = '{
    // The first reading after reset fills the whole window.
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_LO, RD_LO, RD_LO}, '{1'b1, Q_LO, Q_LO, Q_LO}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_HI, RD_HI, RD_HI}, '{1'b1, Q_HI, Q_HI, Q_HI}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{TEMP_MIN_RST, HUM_MIN_RST, PRESS_MIN_RST},
      '{1'b1, Q_LO, Q_LO, Q_LO}},
    '{ROW_READING, CFG_TEMP_MIN, '0,
      '{TEMP_MIN_RST + 24'sd1, HUM_MIN_RST + 24'sd1, PRESS_MIN_RST + 24'sd1},
      '{1'b1, Q_LO, Q_LO, Q_LO}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{24'sd5120, 24'sd12800, 24'sd258048}, '0},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{-24'sd1000, 24'sd0, 24'sd250000}, '0},
    // Zero gains; the humidity and pressure writes carry junk above the gain width.
    '{ROW_WRITE, CFG_TEMP_GAIN, 24'h000000, '0, '0},
    '{ROW_WRITE, CFG_HUM_GAIN, 24'hAB0000, '0, '0},
    '{ROW_WRITE, CFG_PRESS_GAIN, 24'hFF0000, '0, '0},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_HI, RD_HI, RD_HI}, '{1'b1, Q_LO, Q_LO, Q_LO}},
    '{ROW_WRITE, CFG_TEMP_MIN, 24'h800000, '0, '0},
    '{ROW_WRITE, CFG_HUM_MIN, 24'h800000, '0, '0},
    '{ROW_WRITE, CFG_PRESS_MIN, 24'h800000, '0, '0},
    '{ROW_WRITE, CFG_TEMP_GAIN, 24'h00FFFF, '0, '0},
    '{ROW_WRITE, CFG_HUM_GAIN, 24'hFFFFFF, '0, '0},
    '{ROW_WRITE, CFG_PRESS_GAIN, 24'h7FFFFF, '0, '0},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_HI, RD_HI, RD_HI}, '{1'b1, Q_HI, Q_HI, Q_HI}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_LO, RD_LO, RD_LO}, '{1'b1, Q_LO, Q_LO, Q_LO}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{24'sh000001, 24'sh5A5A5A, 24'shA5A5A5}, '0},
    '{ROW_WRITE, CFG_TEMP_MIN, 24'h7FFFFF, '0, '0},
    '{ROW_WRITE, CFG_SPARE_LO, 24'h123456, '0, '0},
    '{ROW_WRITE, CFG_SPARE_HI, 24'hFFFFFF, '0, '0},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{RD_HI, RD_HI, RD_HI}, '{1'b1, Q_LO, Q_HI, Q_HI}},
    '{ROW_READING, CFG_TEMP_MIN, '0, '{24'sd0, 24'sd0, 24'sd0}, '{1'b1, Q_LO, Q_HI, Q_HI}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  swq_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  swq_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0]     cfg_wdata;

  // Predictor state: register copies, the raw reading windows and the primed flag.
  logic signed [DATA_W-1:0] lo_bound [NUM_CH];
  logic [GAIN_W-1:0]        scale [NUM_CH];
  logic signed [DATA_W-1:0] history [NUM_CH][WINDOW_LEN];
  logic                     seeded;

  swq_out_t      expected_slots[$];
  newest_check_t newest_checks[$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;
  bit            hold_request = 1'b0;

  sensor_window_int8_quantizer #(.WINDOW_LEN(WINDOW_LEN)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic signed [Q_W-1:0] quantize(logic signed [DATA_W-1:0] x,
                                                     logic signed [DATA_W-1:0] lo,
                                                     logic [GAIN_W-1:0] gain);
    logic signed [DATA_W:0] d;
    logic [PROD_W-1:0]      u;
    d = x - lo;
    if (d <= 0) return Q_LO;
    u = (PROD_W'(d[DATA_W-1:0]) * PROD_W'(gain)) >> GAIN_W;
    if (u > 255) u = 255;
    return $signed(u[Q_W-1:0] - 8'd128);
  endfunction

  // Shifts one reading into the windows and queues the codes of every slot, oldest first.
  function automatic void predict_window(swq_in_t rd);
    logic signed [DATA_W-1:0] fresh [NUM_CH];
    swq_out_t                 s;
    fresh[0] = rd.temperature;
    fresh[1] = rd.humidity;
    fresh[2] = rd.pressure;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (!seeded) begin
        for (int i = 0; i < WINDOW_LEN; i++) history[ch][i] = fresh[ch];
      end
      for (int i = 0; i < WINDOW_LEN - 1; i++) history[ch][i] = history[ch][i + 1];
      history[ch][WINDOW_LEN - 1] = fresh[ch];
    end
    seeded = 1'b1;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      s.q_temp  = quantize(history[0][i], lo_bound[0], scale[0]);
      s.q_hum   = quantize(history[1][i], lo_bound[1], scale[1]);
      s.q_press = quantize(history[2][i], lo_bound[2], scale[2]);
      s.slot    = SLOT_W'(i);
      s.last    = (i == WINDOW_LEN - 1);
      expected_slots.push_back(s);
    end
  endfunction

  function automatic void note_error(string msg);
    if (errors < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    errors++;
  endfunction

  // Mostly values that land inside the quantizer's range for the current setting,
  // the rest anywhere in the field.
  function automatic logic [DATA_W-1:0] random_value(int ch);
    int          base;
    int unsigned span;
    if ($urandom_range(0, 9) < 3) return DATA_W'($urandom);
    base = lo_bound[ch];
    span = (scale[ch] == 0) ? 32'd65536 : (32'd300 << GAIN_W) / scale[ch];
    return DATA_W'(base + int'($urandom_range(0, span)) - 8);
  endfunction

  task automatic send_reading(swq_in_t rd, newest_check_t mark);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    newest_checks.push_back(mark);
    in_valid <= 1'b1;
    in_data  <= rd;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_channel(int ch, logic [DATA_W-1:0] lo, logic [GAIN_W-1:0] gain);
    write_reg(MIN_IDX[ch], lo);
    write_reg(GAIN_IDX[ch], {8'($urandom), gain});
  endtask

  // Drops valid and waits until every slot has arrived and the pipeline has emptied.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : scoreboard
    newest_check_t mark;
    swq_out_t      want;
    int            tail;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEMP_MIN:   lo_bound[0] = cfg_wdata;
          CFG_TEMP_GAIN:  scale[0]    = cfg_wdata[GAIN_W-1:0];
          CFG_HUM_MIN:    lo_bound[1] = cfg_wdata;
          CFG_HUM_GAIN:   scale[1]    = cfg_wdata[GAIN_W-1:0];
          CFG_PRESS_MIN:  lo_bound[2] = cfg_wdata;
          CFG_PRESS_GAIN: scale[2]    = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_window(in_data);
        mark = newest_checks.pop_front();
        if (mark.chk) begin
          tail = expected_slots.size() - 1;
          expected_slots[tail].q_temp  = mark.q_temp;
          expected_slots[tail].q_hum   = mark.q_hum;
          expected_slots[tail].q_press = mark.q_press;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_slots.size() == 0) begin
          note_error($sformatf("result transfer with nothing expected, slot %0d", out_data.slot));
        end else begin
          want = expected_slots.pop_front();
          if (out_data.q_temp !== want.q_temp || out_data.q_hum !== want.q_hum ||
              out_data.q_press !== want.q_press || out_data.slot !== want.slot ||
              out_data.last !== want.last) begin
            note_error($sformatf(
              "expected %0d/%0d/%0d slot %0d last %0b, got %0d/%0d/%0d slot %0d last %0b",
              want.q_temp, want.q_hum, want.q_press, want.slot, want.last,
              out_data.q_temp, out_data.q_hum, out_data.q_press, out_data.slot, out_data.last));
          end
        end
      end
    end
  end

  // Result side: random stalls, none while calm, and one long hold-off on request.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
    end
  end

  initial begin : stimulus
    swq_in_t rd;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    lo_bound  = '{TEMP_MIN_RST, HUM_MIN_RST, PRESS_MIN_RST};
    scale     = '{TEMP_GAIN_RST, HUM_GAIN_RST, PRESS_GAIN_RST};
    seeded    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (stim_rows[r].kind == ROW_WRITE) begin
        settle();
        write_reg(stim_rows[r].idx, stim_rows[r].wdata);
      end else begin
        send_reading(stim_rows[r].reading, stim_rows[r].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          program_channel(0, TEMP_MIN_RST, TEMP_GAIN_RST);
          program_channel(1, HUM_MIN_RST, HUM_GAIN_RST);
          program_channel(2, PRESS_MIN_RST, PRESS_GAIN_RST);
        end
        1, 2: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            program_channel(ch, DATA_W'(int'($urandom_range(0, 2097152)) - 1048576),
                            GAIN_W'($urandom_range(1, 4000)));
          end
        end
        3: begin
          // Extremes: lowest bound with unit gain, full gain with the bound at zero and near the top.
          program_channel(0, RD_LO, 16'd1);
          program_channel(1, 24'd0, 16'hFFFF);
          program_channel(2, RD_HI - 24'sd300, 16'hFFFF);
        end
        default: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            program_channel(ch, DATA_W'($urandom), GAIN_W'($urandom));
          end
        end
      endcase
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, DATA_W'($urandom));
      // The long hold-off lets the sender keep offering until the block stalls its input.
      if (ph == 1) hold_request = 1'b1;
      calm = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rd.temperature = random_value(0);
        rd.humidity    = random_value(1);
        rd.pressure    = random_value(2);
        send_reading(rd, '0);
      end
    end

    calm = 1'b0;
    settle();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/swq_pkg.sv
rtl/core/swq_ram.sv
rtl/core/swq_ctrl.sv
rtl/core/swq_datapath.sv
rtl/core/sensor_window_int8_quantizer.sv
test/sensor_window_int8_quantizer_tb.sv
